[rtl/core/snp_pkg.sv]
// ----------------------------------------------------------------------------
// snp_pkg
// Shared constants and controller/datapath interface types for the
// binary packet receiver.
// ----------------------------------------------------------------------------
package snp_pkg;

  localparam int MAX_DATA   = 64;
  localparam int ADDR_W     = $clog2(MAX_DATA);
  localparam int LEN_W      = 7;
  localparam int ITEM_BYTES = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] SYNC_S = 8'h73;
  localparam logic [7:0] SYNC_N = 8'h6E;
  localparam logic [7:0] SYNC_P = 8'h70;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HAS_DATA_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_FLAG_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_BASE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE         = 3'd6;

  // Address classes.
  localparam logic [1:0] CLASS_CONFIG  = 2'd0;
  localparam logic [1:0] CLASS_DATA    = 2'd1;
  localparam logic [1:0] CLASS_COMMAND = 2'd2;

  typedef struct packed {
    logic win_shift;
    logic win_clear;
    logic take_type;
    logic take_addr;
    logic store_byte;
    logic take_chkh;
    logic take_chkl;
    logic ctr_clear;
    logic ctr_inc;
    logic rd_issue;
    logic out_load;
  } snp_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic emit_last;
    logic slot_free;
  } snp_stat_t;

endpackage

[rtl/core/snp_ctrl.sv]
// ----------------------------------------------------------------------------
// snp_ctrl
// Parser state machine: walks sync, type, address, payload and checksum
// bytes, then sequences the read-out of the stored payload.
// ----------------------------------------------------------------------------
module snp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  snp_pkg::snp_stat_t stat,
  output snp_pkg::snp_cmd_t  cmd
);
  import snp_pkg::*;

  typedef enum logic [7:0] {
    ST_HUNT = 8'b0000_0001,
    ST_TYPE = 8'b0000_0010,
    ST_ADDR = 8'b0000_0100,
    ST_DATA = 8'b0000_1000,
    ST_CHKH = 8'b0001_0000,
    ST_CHKL = 8'b0010_0000,
    ST_READ = 8'b0100_0000,
    ST_LOAD = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state != ST_READ) && (state != ST_LOAD);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_HUNT: begin
        if (in_fire) begin
          if (stat.sync_hit) begin
            cmd.win_clear = 1'b1;
            cmd.ctr_clear = 1'b1;
            state_next    = ST_TYPE;
          end else begin
            cmd.win_shift = 1'b1;
          end
        end
      end
      ST_TYPE: begin
        if (in_fire) begin
          cmd.take_type = 1'b1;
          if (stat.len_ok) begin
            state_next = ST_ADDR;
          end else begin
            cmd.win_clear = 1'b1;
            state_next    = ST_HUNT;
          end
        end
      end
      ST_ADDR: begin
        if (in_fire) begin
          cmd.take_addr = 1'b1;
          cmd.ctr_clear = 1'b1;
          state_next    = stat.len_zero ? ST_CHKH : ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          if (stat.data_done) begin
            cmd.ctr_clear = 1'b1;
            state_next    = ST_CHKH;
          end else begin
            cmd.ctr_inc = 1'b1;
          end
        end
      end
      ST_CHKH: begin
        if (in_fire) begin
          cmd.take_chkh = 1'b1;
          state_next    = ST_CHKL;
        end
      end
      ST_CHKL: begin
        if (in_fire) begin
          cmd.take_chkl = 1'b1;
          cmd.win_clear = 1'b1;
          cmd.ctr_clear = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_last) begin
            cmd.ctr_clear = 1'b1;
            state_next    = ST_HUNT;
          end else begin
            cmd.ctr_inc = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        cmd.win_clear = 1'b1;
        state_next    = ST_HUNT;
      end
    endcase
  end

endmodule

[rtl/core/snp_dp.sv]
// ----------------------------------------------------------------------------
// snp_dp
// Parser datapath: configuration registers, sync window, header fields,
// payload memory and the output word register.
// ----------------------------------------------------------------------------
module snp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [snp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [snp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                    rx_byte,
  input  snp_pkg::snp_cmd_t              cmd,
  output snp_pkg::snp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pkt_type,
  output logic [7:0]                    reg_address,
  output logic [1:0]                    address_class,
  output logic [snp_pkg::LEN_W-1:0]     payload_length,
  output logic [15:0]                   check_word,
  output logic                          has_byte,
  output logic [snp_pkg::ADDR_W-1:0]    byte_index,
  output logic [7:0]                    payload_byte,
  output logic                          last
);
  import snp_pkg::*;

  // Configuration registers.
  logic [7:0]       has_data_mask;
  logic [7:0]       batch_flag_mask;
  logic [2:0]       batch_count_shift;
  logic [7:0]       batch_count_mask;
  logic [LEN_W-1:0] max_payload;
  logic [7:0]       command_base;
  logic [7:0]       data_base;

  // Parser state.
  logic [15:0]      sync_window;
  logic [1:0]       sync_fill;
  logic [7:0]       held_type;
  logic [7:0]       held_address;
  logic [1:0]       held_class;
  logic [LEN_W-1:0] held_length;
  logic [LEN_W-1:0] byte_counter;
  logic [15:0]      chk_word;

  logic [7:0]       payload_store [MAX_DATA];
  logic [7:0]       rd_data;

  // Type and address decode, and the counter increment.
  logic [7:0]       count_field;
  logic [9:0]       len_full;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] ctr_plus;
  logic [1:0]       class_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_data_mask     <= 8'd128;
      batch_flag_mask   <= 8'd64;
      batch_count_shift <= 3'd2;
      batch_count_mask  <= 8'd15;
      max_payload       <= 7'd60;
      command_base      <= 8'd170;
      data_base         <= 8'd85;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HAS_DATA_MASK:     has_data_mask     <= cfg_data;
        REG_BATCH_FLAG_MASK:   batch_flag_mask   <= cfg_data;
        REG_BATCH_COUNT_SHIFT: batch_count_shift <= cfg_data[2:0];
        REG_BATCH_COUNT_MASK:  batch_count_mask  <= cfg_data;
        REG_MAX_PAYLOAD:       max_payload       <= cfg_data[LEN_W-1:0];
        REG_COMMAND_BASE:      command_base      <= cfg_data;
        REG_DATA_BASE:         data_base         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_field = (rx_byte >> batch_count_shift) & batch_count_mask;
    if ((rx_byte & has_data_mask) == 8'd0) begin
      len_full = 10'd0;
    end else if ((rx_byte & batch_flag_mask) != 8'd0) begin
      len_full = 10'(count_field) * 10'(ITEM_BYTES);
    end else begin
      len_full = 10'(ITEM_BYTES);
    end
    limit = (max_payload > LEN_W'(MAX_DATA)) ? LEN_W'(MAX_DATA) : max_payload;

    priority if (rx_byte >= command_base) begin
      class_next = CLASS_COMMAND;
    end else if (rx_byte > data_base) begin
      class_next = CLASS_DATA;
    end else begin
      class_next = CLASS_CONFIG;
    end

    ctr_plus = byte_counter + LEN_W'(1);
  end

  assign stat.sync_hit  = (sync_fill == 2'd2) && (sync_window == {SYNC_S, SYNC_N})
                          && (rx_byte == SYNC_P);
  assign stat.len_ok    = (len_full <= 10'(limit));
  assign stat.len_zero  = (held_length == '0);
  assign stat.data_done = (ctr_plus >= held_length);
  assign stat.emit_last = (held_length == '0) || (ctr_plus == held_length);
  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window  <= '0;
      sync_fill    <= '0;
      held_type    <= '0;
      held_address <= '0;
      held_class   <= '0;
      held_length  <= '0;
      byte_counter <= '0;
      chk_word     <= '0;
    end else begin
      if (cmd.win_clear) begin
        sync_window <= '0;
        sync_fill   <= '0;
      end else if (cmd.win_shift) begin
        sync_window <= {sync_window[7:0], rx_byte};
        if (sync_fill != 2'd2) begin
          sync_fill <= sync_fill + 2'd1;
        end
      end
      if (cmd.take_type) begin
        held_type <= rx_byte;
        if (stat.len_ok) begin
          held_length <= len_full[LEN_W-1:0];
        end
      end
      if (cmd.take_addr) begin
        held_address <= rx_byte;
        held_class   <= class_next;
      end
      if (cmd.ctr_clear) begin
        byte_counter <= '0;
      end else if (cmd.ctr_inc) begin
        byte_counter <= ctr_plus;
      end
      if (cmd.take_chkh) begin
        chk_word[15:8] <= rx_byte;
      end
      if (cmd.take_chkl) begin
        chk_word[7:0] <= rx_byte;
      end
    end
  end

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      payload_store[byte_counter[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= payload_store[byte_counter[ADDR_W-1:0]];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pkt_type       <= held_type;
      reg_address    <= held_address;
      address_class  <= held_class;
      payload_length <= held_length;
      check_word     <= chk_word;
      has_byte       <= !stat.len_zero;
      byte_index     <= stat.len_zero ? '0 : byte_counter[ADDR_W-1:0];
      payload_byte   <= stat.len_zero ? 8'd0 : rd_data;
      last           <= stat.emit_last;
    end
  end

endmodule

[rtl/core/snp_packet_receiver.sv]
// ----------------------------------------------------------------------------
// snp_packet_receiver
// Binary packet receiver: finds the "snp" sync sequence in a byte stream,
// parses type, address, payload and checksum, and emits the payload as a
// run of output words.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------
//  in       | in_valid / in_ready | rx_byte
//  out      | out_valid/out_ready | pkt_type .. last (one word per byte)
//  cfg      | cfg_we              | cfg_index, cfg_data
//
//  in_ready stays high while parsing. After the checksum's low byte, the
//  payload is read back from the memory's single read port, one output word
//  at a time (read, then load), or one header-only word is loaded; in_ready
//  is low during that run until the last word is loaded. A stalled output
//  holds the word and the run waits. Reset restores the register defaults
//  and the hunting state; there is no clearing pass.
// ----------------------------------------------------------------------------
module snp_packet_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [snp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [snp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pkt_type,
  output logic [7:0]                    reg_address,
  output logic [1:0]                    address_class,
  output logic [snp_pkg::LEN_W-1:0]     payload_length,
  output logic [15:0]                   check_word,
  output logic                          has_byte,
  output logic [snp_pkg::ADDR_W-1:0]    byte_index,
  output logic [7:0]                    payload_byte,
  output logic                          last
);
  import snp_pkg::*;

  snp_cmd_t  cmd;
  snp_stat_t stat;

  snp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  snp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pkt_type       (pkt_type),
    .reg_address    (reg_address),
    .address_class  (address_class),
    .payload_length (payload_length),
    .check_word     (check_word),
    .has_byte       (has_byte),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .last           (last)
  );

endmodule

[rtl/core/snp_checker.sv]
// ----------------------------------------------------------------------------
// snp_checker
// Port-level checks on the packet receiver's output words.
// ----------------------------------------------------------------------------
module snp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    address_class,
  input logic [snp_pkg::LEN_W-1:0]     payload_length,
  input logic                          has_byte,
  input logic [snp_pkg::ADDR_W-1:0]    byte_index,
  input logic [7:0]                    payload_byte,
  input logic                          last
);
  import snp_pkg::*;

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(byte_index)
      && $stable(last))
    else $error("output word changed while stalled");

  // A header-only word is alone in its run and carries no byte.
  a_hdr_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last && byte_index == '0 && payload_byte == 8'd0
      && payload_length == '0)
    else $error("malformed header-only word");

  // Payload words stay inside the payload.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> LEN_W'(byte_index) < payload_length)
    else $error("byte index beyond payload length");

  // The last payload word sits at the end of the payload.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> last == (LEN_W'(byte_index) + LEN_W'(1) == payload_length))
    else $error("last flag on wrong word");

  a_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> address_class == CLASS_CONFIG || address_class == CLASS_DATA
      || address_class == CLASS_COMMAND)
    else $error("invalid address class");

endmodule

bind snp_packet_receiver snp_checker u_snp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .address_class  (address_class),
  .payload_length (payload_length),
  .has_byte       (has_byte),
  .byte_index     (byte_index),
  .payload_byte   (payload_byte),
  .last           (last)
);

[test/tb_snp_packet_receiver.sv]
// ----------------------------------------------------------------------------
// tb_snp_packet_receiver
// Self-checking bench for the binary packet receiver. Bytes are offered with
// random gaps and the output words are taken with random stalls. A
// behavioral model predicts every word. The run starts with a short directed
// table and then goes through phases of random packets under several
// register settings. Each phase ends once all its words have been taken.
// ----------------------------------------------------------------------------
module tb_snp_packet_receiver;
  import snp_pkg::*;

  localparam int DIR_ROWS = 26;
  localparam int PHASES = 7;
  localparam int PHASE_BYTES = 54;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    STEP_HUNT, STEP_TYPE, STEP_ADDR, STEP_DATA, STEP_CHK_HI, STEP_CHK_LO
  } parse_step_t;

  typedef struct packed {
    logic [7:0]        ptype;
    logic [7:0]        addr;
    logic [1:0]        aclass;
    logic [LEN_W-1:0]  plen;
    logic [15:0]       chk;
    logic              has;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        data;
    logic              lastw;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] value;
    logic       typed;
    rx_word_t   word;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            pkt_type;
  logic [7:0]            reg_address;
  logic [1:0]            address_class;
  logic [LEN_W-1:0]      payload_length;
  logic [15:0]           check_word;
  logic                  has_byte;
  logic [ADDR_W-1:0]     byte_index;
  logic [7:0]            payload_byte;
  logic                  last;

  snp_packet_receiver uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .pkt_type(pkt_type), .reg_address(reg_address), .address_class(address_class),
    .payload_length(payload_length), .check_word(check_word), .has_byte(has_byte),
    .byte_index(byte_index), .payload_byte(payload_byte), .last(last)
  );

  always #1 clk = ~clk;

  // Parser copy: register settings and state.
  logic [7:0]       cfg_has_data, cfg_batch_flag, cfg_count_mask, cfg_cmd_base, cfg_data_base;
  logic [2:0]       cfg_count_shift;
  logic [6:0]       cfg_max_len;
  parse_step_t      parse_at;
  logic [15:0]      sync_pair;
  int               pair_fill;
  logic [7:0]       cur_type, cur_addr, chk_hi;
  logic [1:0]       cur_class;
  int               cur_len;
  int               data_count;
  logic [7:0]       payload_mem [MAX_DATA];

  rx_word_t         expected_words [$];
  rx_word_t         got_word, want_word;
  int               mismatches = 0;
  int               packet_bytes;
  bit               send_idle, recv_idle, hold_req;

  logic [7:0]       phase_cfg [PHASES][7];
  stim_row_t        dir_rows [DIR_ROWS];

  function automatic int payload_len(input logic [7:0] t, output bit ok);
    int n;
    int lim;
    lim = (cfg_max_len > MAX_DATA) ? MAX_DATA : int'(cfg_max_len);
    if ((t & cfg_has_data) == 8'd0)
      n = 0;
    else if ((t & cfg_batch_flag) != 8'd0)
      n = ITEM_BYTES * ((int'(t) >> cfg_count_shift) & int'(cfg_count_mask));
    else
      n = ITEM_BYTES;
    ok = (n <= lim);
    return n;
  endfunction

  function automatic rx_word_t make_word(input logic [15:0] chk, input logic has,
                                         input int i, input logic [7:0] data,
                                         input logic lastw);
    rx_word_t w;
    w.ptype = cur_type;
    w.addr = cur_addr;
    w.aclass = cur_class;
    w.plen = cur_len[LEN_W-1:0];
    w.chk = chk;
    w.has = has;
    w.idx = i[ADDR_W-1:0];
    w.data = data;
    w.lastw = lastw;
    return w;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    int  len;
    bit  ok;
    case (parse_at)
      STEP_HUNT: begin
        if (pair_fill >= 2 && sync_pair == {SYNC_S, SYNC_N} && b == SYNC_P) begin
          sync_pair = '0;
          pair_fill = 0;
          data_count = 0;
          parse_at = STEP_TYPE;
        end else begin
          sync_pair = {sync_pair[7:0], b};
          if (pair_fill < 2) pair_fill++;
        end
      end
      STEP_TYPE: begin
        cur_type = b;
        len = payload_len(b, ok);
        if (!ok) begin
          parse_at = STEP_HUNT;
          sync_pair = '0;
          pair_fill = 0;
        end else begin
          cur_len = len;
          parse_at = STEP_ADDR;
        end
      end
      STEP_ADDR: begin
        cur_addr = b;
        if (b >= cfg_cmd_base)
          cur_class = CLASS_COMMAND;
        else if (b > cfg_data_base)
          cur_class = CLASS_DATA;
        else
          cur_class = CLASS_CONFIG;
        data_count = 0;
        parse_at = (cur_len > 0) ? STEP_DATA : STEP_CHK_HI;
      end
      STEP_DATA: begin
        if (data_count < MAX_DATA) payload_mem[data_count] = b;
        data_count++;
        if (data_count >= cur_len) begin
          data_count = 0;
          parse_at = STEP_CHK_HI;
        end
      end
      STEP_CHK_HI: begin
        chk_hi = b;
        parse_at = STEP_CHK_LO;
      end
      default: begin
        // The checksum's low byte closes the packet and releases its words.
        if (cur_len == 0)
          expected_words.push_back(make_word({chk_hi, b}, 1'b0, 0, 8'h00, 1'b1));
        else
          for (int i = 0; i < cur_len; i++)
            expected_words.push_back(make_word({chk_hi, b}, 1'b1, i, payload_mem[i],
                                               i == cur_len - 1));
        parse_at = STEP_HUNT;
        sync_pair = '0;
        pair_fill = 0;
        data_count = 0;
      end
    endcase
  endtask

  // Entered and left at a falling edge; valid is only lowered when a gap is drawn.
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    parse_byte(b);
    offer_byte(b);
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    bit         ok;
    t = 8'($urandom_range(0, 255));
    // Mostly look for a type whose length fits, so packets get past the header.
    if ($urandom_range(0, 4) != 0)
      for (int k = 0; k < 8; k++) begin
        void'(payload_len(t, ok));
        if (ok) break;
        t = 8'($urandom_range(0, 255));
      end
    return t;
  endfunction

  task automatic send_packet(input bit broken);
    int cut;
    cut = broken ? $urandom_range(1, 8) : 1000;
    put_byte(SYNC_S);
    put_byte(SYNC_N);
    put_byte(SYNC_P);
    packet_bytes += 3;
    while (parse_at != STEP_HUNT && cut > 0) begin
      put_byte(parse_at == STEP_TYPE ? pick_type() : 8'($urandom_range(0, 255)));
      packet_bytes++;
      cut--;
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      case ($urandom_range(0, 3))
        0: put_byte(SYNC_S);
        1: put_byte(SYNC_N);
        2: put_byte(SYNC_P);
        default: put_byte(8'($urandom_range(0, 255)));
      endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_HAS_DATA_MASK:     cfg_has_data = v;
      REG_BATCH_FLAG_MASK:   cfg_batch_flag = v;
      REG_BATCH_COUNT_SHIFT: cfg_count_shift = v[2:0];
      REG_BATCH_COUNT_MASK:  cfg_count_mask = v;
      REG_MAX_PAYLOAD:       cfg_max_len = v[6:0];
      REG_COMMAND_BASE:      cfg_cmd_base = v;
      REG_DATA_BASE:         cfg_data_base = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Receiver: a random stall per word, and once a long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = recv_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_word = {pkt_type, reg_address, address_class, payload_length, check_word,
                  has_byte, byte_index, payload_byte, last};
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got %h", $time, got_word);
      end else begin
        want_word = expected_words.pop_front();
        if (got_word !== want_word) begin
          mismatches++;
          if (got_word.ptype !== want_word.ptype)
            $display("%0t: pkt_type expected %h got %h", $time, want_word.ptype,
                     got_word.ptype);
          if (got_word.addr !== want_word.addr)
            $display("%0t: reg_address expected %h got %h", $time, want_word.addr,
                     got_word.addr);
          if (got_word.aclass !== want_word.aclass)
            $display("%0t: address_class expected %0d got %0d", $time, want_word.aclass,
                     got_word.aclass);
          if (got_word.plen !== want_word.plen)
            $display("%0t: payload_length expected %0d got %0d", $time, want_word.plen,
                     got_word.plen);
          if (got_word.chk !== want_word.chk)
            $display("%0t: check_word expected %h got %h", $time, want_word.chk,
                     got_word.chk);
          if (got_word.has !== want_word.has)
            $display("%0t: has_byte expected %b got %b", $time, want_word.has,
                     got_word.has);
          if (got_word.idx !== want_word.idx)
            $display("%0t: byte_index expected %0d got %0d", $time, want_word.idx,
                     got_word.idx);
          if (got_word.data !== want_word.data)
            $display("%0t: payload_byte expected %h got %h", $time, want_word.data,
                     got_word.data);
          if (got_word.lastw !== want_word.lastw)
            $display("%0t: last expected %b got %b", $time, want_word.lastw,
                     got_word.lastw);
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("tb_snp_packet_receiver failed");
    $finish;
  end

  initial begin
    int n0;
    int sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;

    cfg_has_data = 8'd128;
    cfg_batch_flag = 8'd64;
    cfg_count_shift = 3'd2;
    cfg_count_mask = 8'd15;
    cfg_max_len = 7'd60;
    cfg_cmd_base = 8'd170;
    cfg_data_base = 8'd85;
    parse_at = STEP_HUNT;
    sync_pair = '0;
    pair_fill = 0;
    cur_type = '0;
    cur_addr = '0;
    cur_class = CLASS_CONFIG;
    cur_len = 0;
    data_count = 0;
    chk_hi = '0;

    // Order: has data, batch flag, count shift, count mask, max payload,
    // command base, data base.
    phase_cfg = '{
      '{8'd128, 8'd64,  8'd2, 8'd15,  8'd60,  8'd170, 8'd85},
      '{8'd255, 8'd0,   8'd0, 8'd0,   8'd64,  8'd0,   8'd255},
      '{8'd0,   8'd255, 8'd7, 8'd255, 8'd0,   8'd255, 8'd0},
      '{8'd1,   8'd2,   8'd2, 8'd255, 8'd127, 8'd128, 8'd127},
      '{8'd128, 8'd64,  8'd7, 8'd15,  8'd8,   8'd170, 8'd85},
      '{8'd12,  8'd8,   8'd0, 8'd7,   8'd40,  8'd100, 8'd99},
      '{8'd192, 8'd32,  8'd4, 8'd255, 8'd64,  8'd200, 8'd200}
    };

    // Header-only packet, a single item after a stray sync byte, and a batch
    // with a zero count, all under the reset settings.
    dir_rows = '{
      '{8'h73, 1'b0, '0},
      '{8'h6E, 1'b0, '0},
      '{8'h70, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h34, 1'b1, '{8'h00, 8'h00, CLASS_CONFIG, 7'd0, 16'h1234, 1'b0, 6'd0, 8'h00, 1'b1}},
      '{8'h73, 1'b0, '0},
      '{8'h73, 1'b0, '0},
      '{8'h6E, 1'b0, '0},
      '{8'h70, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hA0, 1'b0, '0},
      '{8'hB1, 1'b0, '0},
      '{8'hC2, 1'b0, '0},
      '{8'hD3, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h73, 1'b0, '0},
      '{8'h6E, 1'b0, '0},
      '{8'h70, 1'b0, '0},
      '{8'hC0, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b1, '{8'hC0, 8'hAA, CLASS_COMMAND, 7'd0, 16'h00FF, 1'b0, 6'd0, 8'h00, 1'b1}}
    };

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      n0 = expected_words.size();
      parse_byte(dir_rows[r].value);
      if (dir_rows[r].typed) begin
        while (expected_words.size() > n0) void'(expected_words.pop_back());
        expected_words.push_back(dir_rows[r].word);
      end
      offer_byte(dir_rows[r].value);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_HAS_DATA_MASK,     phase_cfg[p][0]);
      write_reg(REG_BATCH_FLAG_MASK,   phase_cfg[p][1]);
      write_reg(REG_BATCH_COUNT_SHIFT, phase_cfg[p][2]);
      write_reg(REG_BATCH_COUNT_MASK,  phase_cfg[p][3]);
      write_reg(REG_MAX_PAYLOAD,       phase_cfg[p][4]);
      write_reg(REG_COMMAND_BASE,      phase_cfg[p][5]);
      write_reg(REG_DATA_BASE,         phase_cfg[p][6]);
      cfg_we <= 1'b0;
      send_idle = (p % 3 != 0);
      recv_idle = (p % 3 != 1);
      // The first phase carries long payloads, so a held output backs up the input.
      hold_req = (p == 0);
      packet_bytes = 0;
      while (packet_bytes < PHASE_BYTES) begin
        sel = $urandom_range(0, 99);
        if (sel < 75)
          send_packet(1'b0);
        else if (sel < 87)
          send_noise();
        else
          send_packet(1'b1);
      end
      // Finish any open packet so settings never change in the middle of one.
      while (parse_at != STEP_HUNT) put_byte(8'($urandom_range(0, 255)));
      in_valid <= 1'b0;
    end

    while (expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("tb_snp_packet_receiver passed");
    else
      $display("tb_snp_packet_receiver failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/snp_pkg.sv
rtl/core/snp_ctrl.sv
rtl/core/snp_dp.sv
rtl/core/snp_packet_receiver.sv
rtl/core/snp_checker.sv
test/tb_snp_packet_receiver.sv
